// ===== rtl/affc_pkg.sv =====
// shared types and constants for the 2x3 affine matrix composer
// no dependencies

package affc_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int OP_BITS       = 2;
    localparam int FLAG_BITS     = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_LOAD    = 2'd0,
        OP_APPEND  = 2'd1,
        OP_PREPEND = 2'd2,
        OP_COMPARE = 2'd3
    } t_op;

    // packed from the lowest bit: unit matrix, matches input
    typedef struct packed {
        logic matches_input;
        logic unit_mat;
    } t_flags;

endpackage

// ===== rtl/affine_2x3_compose_top.sv =====
// top level of the 2x3 affine matrix composer: input stage, accumulator, result stage
// depends on affc_pkg and affc_compose
//
// channel | dir | tdata (low bit up)                  | tuser (low bit up)
// s       | in  | in_a in_b in_c in_d in_tx in_ty     | operation
// m       | out | out_a out_b out_c out_d out_tx out_ty | unit matrix, matches input
//
// one beat per cycle unless the sink stalls; beats pass input stage then result stage
// the accumulator loop closes through two multiplies, adds and a saturate per element
// reset loads the identity matrix and empties both stages
// a held result stalls the input stage; ready drops once that stage is full

module affine_2x3_compose_top #(
    parameter int WORD_BITS = affc_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = affc_pkg::FRAC_BITS_DEF,
    parameter int DATA_BITS = ((6 * WORD_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [DATA_BITS-1:0]           i_s_tdata,  // in_a in_b in_c in_d in_tx in_ty
    input  logic [affc_pkg::OP_BITS-1:0]   i_s_tuser,  // operation
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [DATA_BITS-1:0]           o_m_tdata,  // out_a out_b out_c out_d out_tx out_ty
    output logic [affc_pkg::FLAG_BITS-1:0] o_m_tuser   // unit matrix, matches input
);

    localparam int W = WORD_BITS;
    localparam logic [W-1:0] QONE = W'(1) << FRAC_BITS;

    logic             r_in_valid;
    affc_pkg::t_op    r_op;
    logic [W-1:0]     r_in_a, r_in_b, r_in_c, r_in_d, r_in_tx, r_in_ty;
    logic [W-1:0]     r_acc_a, r_acc_b, r_acc_c, r_acc_d, r_acc_tx, r_acc_ty;
    logic [W-1:0]     n_acc_a, n_acc_b, n_acc_c, n_acc_d, n_acc_tx, n_acc_ty;
    affc_pkg::t_flags n_flags;
    logic             r_out_valid;
    affc_pkg::t_flags r_out_flags;
    logic [W-1:0]     r_out_a, r_out_b, r_out_c, r_out_d, r_out_tx, r_out_ty;
    logic             w_adv;
    logic             w_take;

    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_take     = i_s_tvalid && o_s_tready;

    affc_compose #(
        .W (W),
        .F (FRAC_BITS)
    ) u_compose (
        .i_op     (r_op),
        .i_acc_a  (r_acc_a),
        .i_acc_b  (r_acc_b),
        .i_acc_c  (r_acc_c),
        .i_acc_d  (r_acc_d),
        .i_acc_tx (r_acc_tx),
        .i_acc_ty (r_acc_ty),
        .i_in_a   (r_in_a),
        .i_in_b   (r_in_b),
        .i_in_c   (r_in_c),
        .i_in_d   (r_in_d),
        .i_in_tx  (r_in_tx),
        .i_in_ty  (r_in_ty),
        .o_a      (n_acc_a),
        .o_b      (n_acc_b),
        .o_c      (n_acc_c),
        .o_d      (n_acc_d),
        .o_tx     (n_acc_tx),
        .o_ty     (n_acc_ty),
        .o_flags  (n_flags)
    );

    // control and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc_a     <= QONE;
            r_acc_b     <= '0;
            r_acc_c     <= '0;
            r_acc_d     <= QONE;
            r_acc_tx    <= '0;
            r_acc_ty    <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_acc_a     <= n_acc_a;
                r_acc_b     <= n_acc_b;
                r_acc_c     <= n_acc_c;
                r_acc_d     <= n_acc_d;
                r_acc_tx    <= n_acc_tx;
                r_acc_ty    <= n_acc_ty;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op    <= affc_pkg::t_op'(i_s_tuser);
            r_in_a  <= i_s_tdata[0*W +: W];
            r_in_b  <= i_s_tdata[1*W +: W];
            r_in_c  <= i_s_tdata[2*W +: W];
            r_in_d  <= i_s_tdata[3*W +: W];
            r_in_tx <= i_s_tdata[4*W +: W];
            r_in_ty <= i_s_tdata[5*W +: W];
        end
        if (w_adv) begin
            r_out_a     <= n_acc_a;
            r_out_b     <= n_acc_b;
            r_out_c     <= n_acc_c;
            r_out_d     <= n_acc_d;
            r_out_tx    <= n_acc_tx;
            r_out_ty    <= n_acc_ty;
            r_out_flags <= n_flags;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_flags;
    assign o_m_tdata  = DATA_BITS'({r_out_ty, r_out_tx, r_out_d, r_out_c, r_out_b, r_out_a});

endmodule

// ===== rtl/affc_dot.sv =====
// one saturating fixed-point dot product with offset: (p*q >>> F) + (r*s >>> F) + t
// no dependencies

module affc_dot #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic signed [W-1:0] i_p,
    input  logic signed [W-1:0] i_q,
    input  logic signed [W-1:0] i_r,
    input  logic signed [W-1:0] i_s,
    input  logic signed [W-1:0] i_t,
    output logic        [W-1:0] o_sum
);

    localparam int PW = 2 * W;
    localparam int FW = PW - F;
    localparam int SW = FW + 2;

    logic signed [PW-1:0]  w_pq;
    logic signed [PW-1:0]  w_rs;
    logic signed [FW-1:0]  w_fpq;
    logic signed [FW-1:0]  w_frs;
    logic signed [SW-1:0]  w_sum;
    logic        [SW-W:0]  w_hi;

    assign w_pq  = i_p * i_q;
    assign w_rs  = i_r * i_s;
    // floor by dropping the fraction bits
    assign w_fpq = w_pq[PW-1:F];
    assign w_frs = w_rs[PW-1:F];
    assign w_sum = SW'(w_fpq) + SW'(w_frs) + SW'(i_t);
    assign w_hi  = w_sum[SW-1:W-1];

    always_comb begin
        if ((&w_hi) || !(|w_hi)) begin
            o_sum = w_sum[W-1:0];
        end else if (w_sum[SW-1]) begin
            o_sum = {1'b1, {(W-1){1'b0}}};
        end else begin
            o_sum = {1'b0, {(W-1){1'b1}}};
        end
    end

endmodule

// ===== rtl/affc_compose.sv =====
// next accumulated matrix and status flags for one beat
// depends on affc_pkg and affc_dot

module affc_compose #(
    parameter int W = affc_pkg::WORD_BITS_DEF,
    parameter int F = affc_pkg::FRAC_BITS_DEF
) (
    input  affc_pkg::t_op  i_op,
    input  logic [W-1:0]   i_acc_a,
    input  logic [W-1:0]   i_acc_b,
    input  logic [W-1:0]   i_acc_c,
    input  logic [W-1:0]   i_acc_d,
    input  logic [W-1:0]   i_acc_tx,
    input  logic [W-1:0]   i_acc_ty,
    input  logic [W-1:0]   i_in_a,
    input  logic [W-1:0]   i_in_b,
    input  logic [W-1:0]   i_in_c,
    input  logic [W-1:0]   i_in_d,
    input  logic [W-1:0]   i_in_tx,
    input  logic [W-1:0]   i_in_ty,
    output logic [W-1:0]   o_a,
    output logic [W-1:0]   o_b,
    output logic [W-1:0]   o_c,
    output logic [W-1:0]   o_d,
    output logic [W-1:0]   o_tx,
    output logic [W-1:0]   o_ty,
    output affc_pkg::t_flags o_flags
);

    localparam logic [W-1:0] QONE = W'(1) << F;
    localparam int NUM_EL = 6;

    logic signed [W-1:0] w_p [NUM_EL];
    logic signed [W-1:0] w_q [NUM_EL];
    logic signed [W-1:0] w_r [NUM_EL];
    logic signed [W-1:0] w_s [NUM_EL];
    logic signed [W-1:0] w_t [NUM_EL];
    logic        [W-1:0] w_dot [NUM_EL];
    logic                w_pre;

    assign w_pre = (i_op == affc_pkg::OP_PREPEND);

    // operand routing: append is acc * in, prepend is in * acc
    always_comb begin
        if (w_pre) begin
            w_p[0] = i_in_a;  w_q[0] = i_acc_a; w_r[0] = i_in_b;  w_s[0] = i_acc_c;
            w_p[1] = i_in_a;  w_q[1] = i_acc_b; w_r[1] = i_in_b;  w_s[1] = i_acc_d;
            w_p[2] = i_in_c;  w_q[2] = i_acc_a; w_r[2] = i_in_d;  w_s[2] = i_acc_c;
            w_p[3] = i_in_c;  w_q[3] = i_acc_b; w_r[3] = i_in_d;  w_s[3] = i_acc_d;
            w_p[4] = i_in_tx; w_q[4] = i_acc_a; w_r[4] = i_in_ty; w_s[4] = i_acc_c;
            w_p[5] = i_in_tx; w_q[5] = i_acc_b; w_r[5] = i_in_ty; w_s[5] = i_acc_d;
            w_t[4] = i_acc_tx;
            w_t[5] = i_acc_ty;
        end else begin
            w_p[0] = i_acc_a;  w_q[0] = i_in_a; w_r[0] = i_acc_b;  w_s[0] = i_in_c;
            w_p[1] = i_acc_a;  w_q[1] = i_in_b; w_r[1] = i_acc_b;  w_s[1] = i_in_d;
            w_p[2] = i_acc_c;  w_q[2] = i_in_a; w_r[2] = i_acc_d;  w_s[2] = i_in_c;
            w_p[3] = i_acc_c;  w_q[3] = i_in_b; w_r[3] = i_acc_d;  w_s[3] = i_in_d;
            w_p[4] = i_acc_tx; w_q[4] = i_in_a; w_r[4] = i_acc_ty; w_s[4] = i_in_c;
            w_p[5] = i_acc_tx; w_q[5] = i_in_b; w_r[5] = i_acc_ty; w_s[5] = i_in_d;
            w_t[4] = i_in_tx;
            w_t[5] = i_in_ty;
        end
        w_t[0] = '0;
        w_t[1] = '0;
        w_t[2] = '0;
        w_t[3] = '0;
    end

    for (genvar g = 0; g < NUM_EL; g++) begin : g_dot
        affc_dot #(
            .W (W),
            .F (F)
        ) u_dot (
            .i_p   (w_p[g]),
            .i_q   (w_q[g]),
            .i_r   (w_r[g]),
            .i_s   (w_s[g]),
            .i_t   (w_t[g]),
            .o_sum (w_dot[g])
        );
    end

    always_comb begin
        case (i_op)
            affc_pkg::OP_LOAD: begin
                o_a  = i_in_a;
                o_b  = i_in_b;
                o_c  = i_in_c;
                o_d  = i_in_d;
                o_tx = i_in_tx;
                o_ty = i_in_ty;
            end
            affc_pkg::OP_APPEND, affc_pkg::OP_PREPEND: begin
                o_a  = w_dot[0];
                o_b  = w_dot[1];
                o_c  = w_dot[2];
                o_d  = w_dot[3];
                o_tx = w_dot[4];
                o_ty = w_dot[5];
            end
            default: begin
                o_a  = i_acc_a;
                o_b  = i_acc_b;
                o_c  = i_acc_c;
                o_d  = i_acc_d;
                o_tx = i_acc_tx;
                o_ty = i_acc_ty;
            end
        endcase
    end

    assign o_flags.unit_mat = (o_a == QONE) && (o_b == '0) && (o_c == '0)
                           && (o_d == QONE) && (o_tx == '0) && (o_ty == '0);
    assign o_flags.matches_input = (i_acc_a == i_in_a) && (i_acc_b == i_in_b)
                                && (i_acc_c == i_in_c) && (i_acc_d == i_in_d)
                                && (i_acc_tx == i_in_tx) && (i_acc_ty == i_in_ty);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// testbench for affine_2x3_compose_top: directed and random matrix beats, each result beat
// checked against a behavioural q16.16 composer kept in this file
// depends on affc_pkg and the rtl of affine_2x3_compose_top

module testbench;

    localparam int DATA_W = 192;
    localparam int FRAC = 16;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] W_MAX = 32'h7fff_ffff;
    localparam logic [31:0] W_MIN = 32'h8000_0000;

    // element a in the lowest bits, ty in the highest
    typedef struct packed {
        logic [31:0] ty, tx, d, c, b, a;
    } t_aff_mat;

    typedef struct packed {
        t_aff_mat mat;
        logic     ident;
        logic     match;
    } t_compose_res;

    typedef enum int {VAL_FULL, VAL_SMALL, VAL_EDGE, VAL_UNIT} t_val_style;

    localparam t_aff_mat MAT_IDENT = '{ty: '0, tx: '0, d: Q_ONE, c: '0, b: '0, a: Q_ONE};

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [DATA_W-1:0]              i_s_tdata;
    logic [affc_pkg::OP_BITS-1:0]   i_s_tuser;
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [DATA_W-1:0]              o_m_tdata;
    logic [affc_pkg::FLAG_BITS-1:0] o_m_tuser;

    t_aff_mat     acc_state;
    t_compose_res pending_mats[$];
    int           err_count = 0;
    bit           src_idle_en;
    bit           sink_stall_en;
    int           stall_left = 0;

    affine_2x3_compose_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // floored products summed exactly, plus an offset, then saturated
    function automatic logic [31:0] qdot(logic [31:0] p, logic [31:0] q, logic [31:0] r,
                                         logic [31:0] s, logic [31:0] t);
        longint sum;
        sum = ((longint'($signed(p)) * longint'($signed(q))) >>> FRAC)
            + ((longint'($signed(r)) * longint'($signed(s))) >>> FRAC)
            + longint'($signed(t));
        if (sum > 64'sd2147483647) return W_MAX;
        if (sum < -64'sd2147483648) return W_MIN;
        return sum[31:0];
    endfunction

    function automatic t_compose_res compose_predict(affc_pkg::t_op op, t_aff_mat m);
        t_compose_res r;
        t_aff_mat s;
        s = acc_state;
        r.match = (s == m);
        case (op)
            affc_pkg::OP_LOAD: begin
                acc_state = m;
            end
            affc_pkg::OP_APPEND: begin
                acc_state.a  = qdot(s.a, m.a, s.b, m.c, '0);
                acc_state.b  = qdot(s.a, m.b, s.b, m.d, '0);
                acc_state.c  = qdot(s.c, m.a, s.d, m.c, '0);
                acc_state.d  = qdot(s.c, m.b, s.d, m.d, '0);
                acc_state.tx = qdot(s.tx, m.a, s.ty, m.c, m.tx);
                acc_state.ty = qdot(s.tx, m.b, s.ty, m.d, m.ty);
            end
            affc_pkg::OP_PREPEND: begin
                acc_state.a  = qdot(m.a, s.a, m.b, s.c, '0);
                acc_state.b  = qdot(m.a, s.b, m.b, s.d, '0);
                acc_state.c  = qdot(m.c, s.a, m.d, s.c, '0);
                acc_state.d  = qdot(m.c, s.b, m.d, s.d, '0);
                acc_state.tx = qdot(m.tx, s.a, m.ty, s.c, s.tx);
                acc_state.ty = qdot(m.tx, s.b, m.ty, s.d, s.ty);
            end
            default: begin
            end
        endcase
        r.mat = acc_state;
        r.ident = (acc_state == MAT_IDENT);
        return r;
    endfunction

    function automatic t_aff_mat mk(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                    logic [31:0] d, logic [31:0] tx, logic [31:0] ty);
        t_aff_mat m;
        m = '{ty: ty, tx: tx, d: d, c: c, b: b, a: a};
        return m;
    endfunction

    function automatic logic [31:0] rand_elem(t_val_style style);
        logic [31:0] picks [7];
        logic [31:0] v;
        picks = '{32'h0, 32'h1, 32'hffff_ffff, W_MAX, W_MIN, Q_ONE, 32'hffff_0000};
        case (style)
            VAL_SMALL: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            VAL_EDGE:  v = picks[$urandom_range(0, 6)];
            VAL_UNIT: begin
                v = Q_ONE + $urandom_range(0, 4095) - 2048;
                if ($urandom_range(0, 1)) v = -v;
            end
            default:   v = $urandom();
        endcase
        return v;
    endfunction

    // one input beat; the expectation is formed at the edge that takes it
    task automatic send_beat(affc_pkg::t_op op, t_aff_mat m);
        t_compose_res res;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= m;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        res = compose_predict(op, m);
        pending_mats = {pending_mats, res};
    endtask

    // sink side: tready dropped in stall bursts of random length while stalls are enabled
    always @(posedge i_clk) begin
        if (!sink_stall_en) begin
            i_m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 6);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_compose_res got;
        t_compose_res want;
        affc_pkg::t_flags flags;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            flags = affc_pkg::t_flags'(o_m_tuser);
            got.mat = t_aff_mat'(o_m_tdata);
            got.ident = flags.unit_mat;
            got.match = flags.matches_input;
            if (pending_mats.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result beat: %h id=%b match=%b",
                             got.mat, got.ident, got.match);
            end else begin
                want = pending_mats.pop_front();
                if (got.mat.a !== want.mat.a || got.mat.b !== want.mat.b ||
                    got.mat.c !== want.mat.c || got.mat.d !== want.mat.d ||
                    got.mat.tx !== want.mat.tx || got.mat.ty !== want.mat.ty ||
                    got.ident !== want.ident || got.match !== want.match) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: expected %h id=%b match=%b, got %h id=%b match=%b",
                                 want.mat, want.ident, want.match,
                                 got.mat, got.ident, got.match);
                end
            end
        end
    end

    task automatic test_reset_state();
        send_beat(affc_pkg::OP_COMPARE, MAT_IDENT);
        send_beat(affc_pkg::OP_COMPARE, mk('0, '0, '0, '0, '0, '0));
        send_beat(affc_pkg::OP_APPEND, MAT_IDENT);
        send_beat(affc_pkg::OP_PREPEND, MAT_IDENT);
    endtask

    task automatic test_load_extremes();
        send_beat(affc_pkg::OP_LOAD, mk(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
        send_beat(affc_pkg::OP_COMPARE, mk(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
        send_beat(affc_pkg::OP_LOAD, mk(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
        send_beat(affc_pkg::OP_LOAD, mk(W_MAX, W_MIN, 32'h0, 32'hffff_ffff, 32'h1, W_MIN));
        send_beat(affc_pkg::OP_LOAD, MAT_IDENT);
    endtask

    task automatic test_compose_basic();
        send_beat(affc_pkg::OP_LOAD, mk(32'h0002_0000, 32'h0, 32'h0, 32'h0002_0000,
                                        32'h0001_8000, 32'hfffe_0000));
        send_beat(affc_pkg::OP_APPEND, mk(32'h0, 32'hffff_0000, Q_ONE, 32'h0,
                                          32'h0003_0000, 32'h0000_4000));
        send_beat(affc_pkg::OP_PREPEND, mk(32'h0000_8000, 32'h0001_4000, 32'hffff_c000,
                                           32'h0000_c000, 32'h0010_0000, 32'hfff0_0000));
        send_beat(affc_pkg::OP_APPEND, MAT_IDENT);
        send_beat(affc_pkg::OP_PREPEND, MAT_IDENT);
    endtask

    // negative products must round toward minus infinity
    task automatic test_floor_negative();
        send_beat(affc_pkg::OP_LOAD, mk(32'hffff_ffff, 32'h3, 32'h0000_7fff, 32'hffff_8001,
                                        32'hffff_ffff, 32'h1));
        send_beat(affc_pkg::OP_APPEND, mk(32'h1, 32'hffff_fffd, 32'h0000_8001, 32'h0000_7fff,
                                          32'h0, 32'h0));
        send_beat(affc_pkg::OP_PREPEND, mk(32'hffff_8000, 32'h0000_0003, 32'hffff_ffff,
                                           32'h0001_0001, 32'hffff_fff1, 32'h0000_000f));
    endtask

    task automatic test_saturation();
        send_beat(affc_pkg::OP_LOAD, mk(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
        send_beat(affc_pkg::OP_APPEND, mk(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
        send_beat(affc_pkg::OP_APPEND, mk(W_MIN, W_MAX, W_MIN, W_MIN, W_MIN, W_MAX));
        send_beat(affc_pkg::OP_LOAD, mk(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
        send_beat(affc_pkg::OP_PREPEND, mk(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
        send_beat(affc_pkg::OP_LOAD, mk(Q_ONE, 32'h0, 32'h0, Q_ONE, W_MAX, W_MIN));
        send_beat(affc_pkg::OP_APPEND, mk(Q_ONE, 32'h0, 32'h0, Q_ONE, W_MAX, W_MIN));
        send_beat(affc_pkg::OP_PREPEND, mk(Q_ONE, 32'h0, 32'h0, Q_ONE, W_MIN, W_MAX));
    endtask

    // mostly chains of compositions, with loads to pull the state back into range
    task automatic test_random_chains(int n);
        affc_pkg::t_op op;
        t_aff_mat m;
        t_val_style style;
        int roll;
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) op = affc_pkg::OP_LOAD;
            else if (roll < 46) op = affc_pkg::OP_APPEND;
            else if (roll < 80) op = affc_pkg::OP_PREPEND;
            else op = affc_pkg::OP_COMPARE;
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                m = MAT_IDENT;
            end else if (roll < 14) begin
                m = acc_state;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 55) style = VAL_SMALL;
                else if (roll < 70) style = VAL_UNIT;
                else style = VAL_FULL;
                m.a  = rand_elem(roll >= 85 ? t_val_style'($urandom_range(0, 3)) : style);
                m.b  = rand_elem(roll >= 85 ? t_val_style'($urandom_range(0, 3)) : style);
                m.c  = rand_elem(roll >= 85 ? t_val_style'($urandom_range(0, 3)) : style);
                m.d  = rand_elem(roll >= 85 ? t_val_style'($urandom_range(0, 3)) : style);
                m.tx = rand_elem(roll >= 85 ? t_val_style'($urandom_range(0, 3)) : style);
                m.ty = rand_elem(roll >= 85 ? t_val_style'($urandom_range(0, 3)) : style);
            end
            send_beat(op, m);
        end
    endtask

    task automatic test_back_to_back(int n);
        src_idle_en = 1'b0;
        sink_stall_en = 1'b0;
        test_random_chains(n);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= affc_pkg::OP_COMPARE;
        acc_state = MAT_IDENT;
        src_idle_en = 1'b1;
        sink_stall_en = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_load_extremes();
        test_compose_basic();
        test_floor_negative();
        test_saturation();
        test_random_chains(1550);
        test_back_to_back(276);

        i_s_tvalid <= 1'b0;
        while (pending_mats.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0 && pending_mats.size() == 0)
            $display("PASS affine_2x3_compose_top");
        else
            $display("FAIL affine_2x3_compose_top");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL affine_2x3_compose_top");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/affc_pkg.sv
rtl/affc_dot.sv
rtl/affc_compose.sv
rtl/affine_2x3_compose_top.sv
bench/testbench.sv
